// File: hdl/hsp_pkg.sv
`default_nettype none

package hsp_pkg;

    // Table geometry; the slot and count fields are sized for this depth.
    localparam int unsigned TABLE_SIZE  = 1024;
    localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
    localparam int unsigned PROBE_LIMIT = TABLE_SIZE + 16;
    localparam int unsigned PROBE_W     = $clog2(PROBE_LIMIT);
    localparam int unsigned LOAD_W      = IDX_W + 2;

    localparam int unsigned KEY_BITS    = 64;
    localparam int unsigned HASH_W      = 64;
    localparam int unsigned PERTURB_SH  = 5;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_INSERT   = 2'd0;
    localparam t_func FUNC_READ     = 2'd1;
    localparam t_func FUNC_CLEAR    = 2'd2;
    localparam t_func FUNC_READ_ALT = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_HOLDS     = 3'd4;
    localparam t_status ST_CLEARED   = 3'd5;

    typedef struct packed {
        t_status               status;
        logic [IDX_W-1:0]      slot;
        logic [KEY_BITS-1:0]   key_out;
        logic [IDX_W-1:0]      used_count;
        logic                  load_high;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      addr;
    } t_mem_ctl;

    // Flag a table past two-thirds occupancy.
    function automatic logic f_load_high(input logic [IDX_W-1:0] count);
        logic [LOAD_W-1:0] count3;
        count3 = LOAD_W'(count) + LOAD_W'({count, 1'b0});
        return count3 > LOAD_W'(2 * TABLE_SIZE);
    endfunction

endpackage

`default_nettype wire

// File: hdl/hsp_if.sv
`default_nettype none

interface hsp_req_if
    import hsp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    t_func                 func;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_W-1:0]     key_hash;
    logic [IDX_W-1:0]      slot_index;

    modport source (output valid, output func, output key, output key_hash,
                    output slot_index, input ready);
    modport sink   (input valid, input func, input key, input key_hash,
                    input slot_index, output ready);
endinterface

interface hsp_rsp_if
    import hsp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic [IDX_W-1:0]      slot;
    logic [KEY_BITS-1:0]   key_out;
    logic [IDX_W-1:0]      used_count;
    logic                  load_high;

    modport source (output valid, output status, output slot, output key_out,
                    output used_count, output load_high, input ready);
    modport sink   (input valid, input status, input slot, input key_out,
                    input used_count, input load_high, output ready);
endinterface

`default_nettype wire

// File: hdl/hash_set_perturbed_probe_unit.sv
// An insert takes P probes (1 to 1040) at one probe per cycle on the single-port slot
// memory. A new word is taken only after the previous result has passed to the output
// register; a clear is followed by a sweep that writes every slot empty, with ready low.
// Reset: synchronous, active low; it empties the count and output stage, then the
// same sweep marks every slot empty before the first word is taken.
`default_nettype none

module hash_set_perturbed_probe_unit
    import hsp_pkg::*;
#(
    parameter int unsigned KEY_WIDTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hsp_req_if.sink   i_req,
    hsp_rsp_if.source o_rsp
);

    // Each slot word packs the valid flag, the stored hash and the key.
    localparam int unsigned WORD_W = 1 + HASH_W + KEY_WIDTH;

    t_mem_ctl          mem_ctl;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    t_result           out_res;
    logic              out_valid;

    // Probe sequencer: decode the word, walk the probe chain, update the table.
    hsp_probe_ctrl #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_ctl),
        .o_wdata     (mem_wdata),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Slot store: one port, registered read data.
    hsp_slot_ram #(
        .WORD_W (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Output register: lets the sequencer take the next word while a result waits.
    hsp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (out_valid),
        .i_ready     (o_rsp.ready),
        .o_res       (out_res)
    );

    assign o_rsp.valid      = out_valid;
    assign o_rsp.status     = out_res.status;
    assign o_rsp.slot       = out_res.slot;
    assign o_rsp.key_out    = out_res.key_out;
    assign o_rsp.used_count = out_res.used_count;
    assign o_rsp.load_high  = out_res.load_high;

endmodule

`default_nettype wire

// File: hdl/hsp_slot_ram.sv
`default_nettype none

module hsp_slot_ram
    import hsp_pkg::*;
#(
    parameter int unsigned WORD_W = 129
) (
    input  wire logic              i_clk,
    input  t_mem_ctl               i_ctl,
    input  wire logic [WORD_W-1:0] i_wdata,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [TABLE_SIZE];

    // Single port: write or read; read data is registered and appears in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_ctl.addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/hsp_probe_ctrl.sv
`default_nettype none

module hsp_probe_ctrl
    import hsp_pkg::*;
#(
    parameter  int unsigned KEY_WIDTH = 64,
    localparam int unsigned WORD_W    = 1 + HASH_W + KEY_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    hsp_req_if.sink                i_req,
    output t_mem_ctl               o_mem,
    output logic      [WORD_W-1:0] o_wdata,
    input  wire logic [WORD_W-1:0] i_rdata,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_RESULT
    } t_state;

    t_state                 r_state;
    t_func                  r_func;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [HASH_W-1:0]      r_hash;
    logic [HASH_W-1:0]      r_perturb;
    logic [IDX_W-1:0]       r_idx;
    logic [PROBE_W-1:0]     r_probe;
    logic [IDX_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_clr_addr;
    t_result                r_res;

    logic                   accept;
    logic                   rd_valid;
    logic [HASH_W-1:0]      rd_hash;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic                   hit;
    logic                   last;
    logic                   room;
    logic [IDX_W-1:0]       next_idx;
    logic [IDX_W-1:0]       n_count;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign rd_valid = i_rdata[WORD_W-1];
    assign rd_hash  = i_rdata[WORD_W-2 -: HASH_W];
    assign rd_key   = i_rdata[KEY_WIDTH-1:0];

    // Stop on an empty slot or on an entry whose hash and key both match.
    assign hit  = !rd_valid || (rd_hash == r_hash && rd_key == r_key);
    assign last = (r_probe == PROBE_W'(PROBE_LIMIT - 1));
    assign room = (r_count < IDX_W'(TABLE_SIZE - 1));

    // idx = 5*idx + perturb + 1, kept modulo the table size.
    assign next_idx = r_idx + {r_idx[IDX_W-3:0], 2'b00} + r_perturb[IDX_W-1:0]
                    + IDX_W'(1);
    assign n_count  = r_count + IDX_W'(1);

    always_comb begin
        o_mem.we   = 1'b0;
        o_mem.addr = r_idx;
        o_wdata    = {1'b1, r_hash, r_key};
        unique case (r_state)
            S_CLEAR: begin
                o_mem.we   = 1'b1;
                o_mem.addr = r_clr_addr;
                o_wdata    = '0;
            end
            S_IDLE: begin
                if (i_req.func == FUNC_INSERT) begin
                    o_mem.addr = i_req.key_hash[IDX_W-1:0];
                end else begin
                    o_mem.addr = i_req.slot_index[IDX_W-1:0];
                end
            end
            S_PROBE: begin
                if (r_func == FUNC_INSERT) begin
                    if (hit) begin
                        o_mem.we = !rd_valid && room;
                    end else begin
                        o_mem.addr = next_idx;
                    end
                end
            end
            S_RESULT: begin
                o_mem.we = 1'b0;
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IDX_W'(1);
                    if (r_clr_addr == IDX_W'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_func    <= i_req.func;
                        r_key     <= i_req.key[KEY_WIDTH-1:0];
                        r_hash    <= i_req.key_hash;
                        r_perturb <= i_req.key_hash;
                        r_probe   <= '0;
                        case (i_req.func) inside
                            FUNC_INSERT: begin
                                r_idx   <= i_req.key_hash[IDX_W-1:0];
                                r_state <= S_PROBE;
                            end
                            FUNC_CLEAR: begin
                                r_count            <= '0;
                                r_res.status       <= ST_CLEARED;
                                r_res.slot         <= '0;
                                r_res.key_out      <= '0;
                                r_res.used_count   <= '0;
                                r_res.load_high    <= 1'b0;
                                r_state            <= S_RESULT;
                            end
                            FUNC_READ, FUNC_READ_ALT: begin
                                r_idx   <= i_req.slot_index[IDX_W-1:0];
                                r_state <= S_PROBE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PROBE: begin
                    r_res.key_out    <= '0;
                    r_res.slot       <= '0;
                    r_res.used_count <= r_count;
                    r_res.load_high  <= f_load_high(r_count);
                    if (r_func == FUNC_INSERT) begin
                        if (hit) begin
                            r_state <= S_RESULT;
                            if (rd_valid) begin
                                r_res.status <= ST_DUPLICATE;
                                r_res.slot   <= r_idx;
                            end else if (room) begin
                                r_count          <= n_count;
                                r_res.status     <= ST_INSERTED;
                                r_res.slot       <= r_idx;
                                r_res.used_count <= n_count;
                                r_res.load_high  <= f_load_high(n_count);
                            end else begin
                                r_res.status <= ST_FULL;
                            end
                        end else if (last) begin
                            r_res.status <= ST_FULL;
                            r_state      <= S_RESULT;
                        end else begin
                            r_idx     <= next_idx;
                            r_perturb <= r_perturb >> PERTURB_SH;
                            r_probe   <= r_probe + PROBE_W'(1);
                        end
                    end else begin
                        r_res.slot    <= r_idx;
                        r_res.status  <= rd_valid ? ST_HOLDS : ST_EMPTY;
                        r_res.key_out <= rd_valid ? KEY_BITS'(rd_key) : '0;
                        r_state       <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_clr_addr <= '0;
                        r_state    <= (r_func == FUNC_CLEAR) ? S_CLEAR : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: hdl/hsp_out_stage.sv
`default_nettype none

module hsp_out_stage
    import hsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_res_valid,
    output logic      o_res_ready,
    input  t_result   i_res,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the word while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: hdl/hsp_checker.sv
`default_nettype none

module hsp_checker
    import hsp_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire t_status             i_status,
    input wire logic [IDX_W-1:0]    i_slot,
    input wire logic [KEY_BITS-1:0] i_key_out,
    input wire logic [IDX_W-1:0]    i_used_count,
    input wire logic                i_load_high
);

    // Hold the result word while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_slot)
            && $stable(i_key_out) && $stable(i_used_count))
        else $error("result payload changed while stalled");

    // The table sweep follows reset, so no word is taken in the next cycle.
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready straight after reset");

    a_clear_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_CLEARED |->
            i_used_count == '0 && !i_load_high && i_slot == '0 && i_key_out == '0)
        else $error("clear result with non-zero fields");

    a_insert_key_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_INSERTED || i_status == ST_DUPLICATE
            || i_status == ST_FULL) |-> i_key_out == '0)
        else $error("insert result carries a key");

endmodule

bind hash_set_perturbed_probe_unit hsp_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot       (o_rsp.slot),
    .i_key_out    (o_rsp.key_out),
    .i_used_count (o_rsp.used_count),
    .i_load_high  (o_rsp.load_high)
);

`default_nettype wire

// File: dv/hash_set_perturbed_probe_unit_tb.sv
`default_nettype none

module hash_set_perturbed_probe_unit_tb;
    import hsp_pkg::*;

    localparam int unsigned KEY_WIDTH      = 64;
    localparam logic [KEY_BITS-1:0] KEY_MASK =
        (KEY_WIDTH >= 64) ? '1 : ((64'd1 << KEY_WIDTH) - 64'd1);
    // A worst-case insert walks the whole probe limit, and a clear sweeps every
    // slot with ready low; allow several times the longer of the two.
    localparam int unsigned WATCHDOG_LIMIT = 10000;
    localparam int unsigned DRAIN_CYCLES   = PROBE_LIMIT + 64;
    localparam int unsigned RANDOM_WORDS   = 160;
    localparam int unsigned GAP_PERCENT    = 22;
    localparam int unsigned MAX_REPORTS    = 10;

    // One key held in the mirror table, kept so that later words can hit it.
    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic [HASH_W-1:0]   hash;
        logic [IDX_W-1:0]    slot;
    } t_stored;

    logic        clk;
    logic        rst_n;
    bit          no_gaps;
    int unsigned errors;
    int unsigned idle_cycles;

    // Mirror of the slot memory and the occupancy count.
    logic                tbl_valid [TABLE_SIZE];
    logic [KEY_BITS-1:0] tbl_key   [TABLE_SIZE];
    logic [HASH_W-1:0]   tbl_hash  [TABLE_SIZE];
    int unsigned         tbl_count;

    t_stored stored_q[$];
    t_result expected_q[$];
    t_result got_word;
    t_result want_word;

    hsp_req_if req_if ();
    hsp_rsp_if rsp_if ();

    hash_set_perturbed_probe_unit #(
        .KEY_WIDTH(KEY_WIDTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror table
    // ------------------------------------------------------------------

    // Empty every slot and forget the remembered keys.
    function automatic void empty_table();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_hash[i]  = '0;
        end
        tbl_count = 0;
        stored_q.delete();
    endfunction

    // A probe stops at an empty slot, or at one holding both this key and this hash.
    function automatic bit probe_stops(input logic [IDX_W-1:0] s,
                                       input logic [KEY_BITS-1:0] key,
                                       input logic [HASH_W-1:0] hash);
        if (!tbl_valid[s])
            return 1'b1;
        return (tbl_hash[s] == hash) && (tbl_key[s] == key);
    endfunction

    // Walk the perturbed sequence; the running index stays 64 bits wide and only
    // its remainder addresses the table. Perturb shifts as an unsigned value.
    function automatic bit locate_slot(input logic [KEY_BITS-1:0] key,
                                       input logic [HASH_W-1:0] hash,
                                       output logic [IDX_W-1:0] where);
        logic [63:0]      pos;
        logic [63:0]      pert;
        logic [IDX_W-1:0] s;
        pos   = hash;
        pert  = hash;
        where = '0;
        s     = IDX_W'(pos % 64'(TABLE_SIZE));
        if (probe_stops(s, key, hash)) begin
            where = s;
            return 1'b1;
        end
        for (int n = 1; n < PROBE_LIMIT; n++) begin
            pos = 64'd5 * pos + pert + 64'd1;
            s   = IDX_W'(pos % 64'(TABLE_SIZE));
            if (probe_stops(s, key, hash)) begin
                where = s;
                return 1'b1;
            end
            pert = pert >> PERTURB_SH;
        end
        return 1'b0;
    endfunction

    // Apply one accepted request word to the mirror and return the result word
    // the block must give for it.
    function automatic t_result predict_word(input t_func f,
                                             input logic [KEY_BITS-1:0] key_in,
                                             input logic [HASH_W-1:0] hash,
                                             input logic [IDX_W-1:0] idx);
        t_result          r;
        logic [KEY_BITS-1:0] key;
        logic [IDX_W-1:0] s;
        bit               found;
        t_stored          e;
        r   = '0;
        key = key_in & KEY_MASK;
        case (f)
            FUNC_INSERT: begin
                found = locate_slot(key, hash, s);
                if (!found) begin
                    r.status = ST_FULL;
                end else if (tbl_valid[s]) begin
                    r.status = ST_DUPLICATE;
                    r.slot   = s;
                end else if (tbl_count >= TABLE_SIZE - 1) begin
                    // one empty slot must always remain
                    r.status = ST_FULL;
                end else begin
                    tbl_valid[s] = 1'b1;
                    tbl_key[s]   = key;
                    tbl_hash[s]  = hash;
                    tbl_count++;
                    r.status = ST_INSERTED;
                    r.slot   = s;
                    e.key    = key;
                    e.hash   = hash;
                    e.slot   = s;
                    stored_q.push_back(e);
                end
            end
            FUNC_CLEAR: begin
                empty_table();
                r.status = ST_CLEARED;
            end
            default: begin
                // both read codes behave the same
                r.slot = idx;
                if (tbl_valid[idx]) begin
                    r.status  = ST_HOLDS;
                    r.key_out = tbl_key[idx];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
        endcase
        r.used_count = IDX_W'(tbl_count);
        r.load_high  = (3 * tbl_count > 2 * TABLE_SIZE);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one word, idling first at random, and predict it once taken.
    // Valid stays high into the next word when no gap is drawn.
    task automatic send_word(input t_func f,
                             input logic [KEY_BITS-1:0] key,
                             input logic [HASH_W-1:0] hash,
                             input logic [IDX_W-1:0] idx);
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= f;
        req_if.key        <= key;
        req_if.key_hash   <= hash;
        req_if.slot_index <= idx;
        do begin
            @(posedge clk);
        end while (!req_if.ready);
        expected_q.push_back(predict_word(f, key, hash, idx));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel at random, except during the steady stretch.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            got_word.status     = rsp_if.status;
            got_word.slot       = rsp_if.slot;
            got_word.key_out    = rsp_if.key_out;
            got_word.used_count = rsp_if.used_count;
            got_word.load_high  = rsp_if.load_high;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word: status %0d slot %0d key %h used %0d load %0b",
                             got_word.status, got_word.slot, got_word.key_out,
                             got_word.used_count, got_word.load_high);
            end else begin
                want_word = expected_q.pop_front();
                if (got_word !== want_word) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected status %0d slot %0d key %h used %0d load %0b",
                                 want_word.status, want_word.slot, want_word.key_out,
                                 want_word.used_count, want_word.load_high);
                        $display("          actual   status %0d slot %0d key %h used %0d load %0b",
                                 got_word.status, got_word.slot, got_word.key_out,
                                 got_word.used_count, got_word.load_high);
                    end
                end
            end
        end
    end

    // Abort if neither channel moves a word for too long.
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("hash_set_perturbed_probe_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Read the freshly reset table at both ends, once through the spare read code.
    task automatic test_empty_reads();
        send_word(FUNC_READ, '0, '0, '0);
        send_word(FUNC_READ, '1, '1, '1);
        send_word(FUNC_READ_ALT, rand64(), rand64(), IDX_W'(512));
    endtask

    // Extreme keys and hashes, a duplicate, the same key under another hash,
    // and collisions on an occupied first slot.
    task automatic test_insert_basics();
        send_word(FUNC_INSERT, '0, '0, '1);
        send_word(FUNC_INSERT, '1, '1, '0);
        send_word(FUNC_INSERT, '1, '1, '0);
        send_word(FUNC_INSERT, '1, '0, '0);
        send_word(FUNC_INSERT, 64'd1, '0, '0);
        send_word(FUNC_INSERT, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FC00, '0);
        send_word(FUNC_READ, '0, '0, stored_q[$].slot);
        send_word(FUNC_READ_ALT, '0, '0, stored_q[$].slot);
        send_word(FUNC_READ, '0, '0, '0);
    endtask

    // Clear, check that a slot reads empty, insert one key, read that slot again, clear again.
    task automatic test_clear();
        send_word(FUNC_CLEAR, rand64(), rand64(), IDX_W'($urandom));
        send_word(FUNC_READ, '0, '0, '1);
        send_word(FUNC_INSERT, '1, '1, '0);
        send_word(FUNC_READ, '0, '0, '1);
        send_word(FUNC_CLEAR, '0, '0, '0);
    endtask

    // Fill until one free slot is left; then a new key is refused while a stored
    // one still reports duplicate.
    task automatic test_fill();
        t_stored e;
        while (tbl_count < TABLE_SIZE - 1)
            send_word(FUNC_INSERT, rand64(), rand64(), IDX_W'($urandom));
        send_word(FUNC_INSERT, rand64(), rand64(), '0);
        e = stored_q[$urandom_range(stored_q.size() - 1)];
        send_word(FUNC_INSERT, e.key, e.hash, '0);
        send_word(FUNC_INSERT, e.key, ~e.hash, '0);
        send_word(FUNC_READ, '0, '0, e.slot);
        send_word(FUNC_READ_ALT, '0, '0, IDX_W'($urandom));
        send_word(FUNC_CLEAR, '0, '0, '0);
    endtask

    // Mixed traffic: mostly inserts that revisit stored keys or their first
    // slots, reads half aimed at live slots, the odd clear.
    task automatic test_random();
        int unsigned         pick;
        t_func               f;
        logic [KEY_BITS-1:0] key;
        logic [HASH_W-1:0]   hash;
        logic [IDX_W-1:0]    idx;
        t_stored             e;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // hold both sides steady for a long stretch in the middle
            no_gaps = (n >= 40) && (n < 120);
            pick = $urandom_range(99);
            key  = rand64();
            hash = rand64();
            idx  = IDX_W'($urandom);
            if (pick == 0 && $urandom_range(2) == 0) begin
                f = FUNC_CLEAR;
            end else if (pick < 31) begin
                f = (pick < 16) ? FUNC_READ : FUNC_READ_ALT;
                if (stored_q.size() != 0 && $urandom_range(1) == 1)
                    idx = stored_q[$urandom_range(stored_q.size() - 1)].slot;
            end else begin
                f = FUNC_INSERT;
                if (stored_q.size() != 0) begin
                    e = stored_q[$urandom_range(stored_q.size() - 1)];
                    if (pick < 50) begin
                        key  = e.key;
                        hash = e.hash;
                    end else if (pick < 58) begin
                        key = e.key;
                    end else if (pick < 72) begin
                        hash = {hash[HASH_W-1:IDX_W], e.hash[IDX_W-1:0]};
                    end
                end
                if (pick >= 96)
                    key = pick[0] ? '0 : '1;
            end
            send_word(f, key, hash, idx);
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        errors      = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        empty_table();
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= FUNC_INSERT;
        req_if.key        <= '0;
        req_if.key_hash   <= '0;
        req_if.slot_index <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_insert_basics();
        test_clear();
        test_fill();
        test_random();
        req_if.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        errors += expected_q.size();

        if (errors == 0) begin
            $display("hash_set_perturbed_probe_unit test passed");
        end else begin
            $display("hash_set_perturbed_probe_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: hash_set_perturbed_probe_unit.f
hdl/hsp_pkg.sv
hdl/hsp_if.sv
hdl/hsp_slot_ram.sv
hdl/hsp_probe_ctrl.sv
hdl/hsp_out_stage.sv
hdl/hash_set_perturbed_probe_unit.sv
hdl/hsp_checker.sv
dv/hash_set_perturbed_probe_unit_tb.sv
